/* sv/thrust_mapping_rls_estimator_top_assert.svh */
// assertion macros for the thrust mapping estimator
// depends on i_clk and i_rst_n in the module that includes this file
`ifndef THRUST_MAPPING_RLS_ESTIMATOR_TOP_ASSERT_SVH
`define THRUST_MAPPING_RLS_ESTIMATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define TMRE_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    prop) else $error("thrust mapping estimator assertion failed");
`define TMRE_NEVER(lbl, cond) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    !(cond)) else $error("thrust mapping estimator forbidden condition");
`else
`define TMRE_ASSERT(lbl, prop)
`define TMRE_NEVER(lbl, cond)
`endif
`endif

/* sv/thrmap_pkg.sv */
// shared types and constants of the thrust mapping estimator
// no dependencies
`timescale 1ns / 1ps
package thrmap_pkg;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        timestamp_us;
        logic signed [31:0] desired_accel;
        logic signed [31:0] measured_accel;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] thrust_command;
        logic               updated;
        logic signed [31:0] gain_estimate;
        logic [7:0]         history_count;
    } t_out_item;

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_GRAVITY = 3'd0;
    localparam logic [2:0] REG_HOVER   = 3'd1;
    localparam logic [2:0] REG_FORGET  = 3'd2;
    localparam logic [2:0] REG_MIN_AGE = 3'd3;
    localparam logic [2:0] REG_MAX_AGE = 3'd4;

    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_MEAS = 2'd1;
    localparam logic [1:0] MODE_RST  = 2'd2;

    localparam logic [21:0] GRAVITY_RST = 22'd642908;
    localparam logic [15:0] HOVER_RST   = 16'd19661;
    localparam logic [16:0] FORGET_RST  = 17'd65405;
    localparam logic [19:0] MIN_AGE_RST = 20'd35000;
    localparam logic [19:0] MAX_AGE_RST = 20'd45000;

    localparam logic [31:0] GAIN_RST = 32'((64'(GRAVITY_RST) << 16) / 64'(HOVER_RST));
    localparam logic [63:0] COV_RST  = 64'd1000000 << 32;

    localparam logic [7:0] DIV_STEPS_CMD  = 8'd48;
    localparam logic [7:0] DIV_STEPS_RST  = 8'd38;
    localparam logic [7:0] DIV_STEPS_MEAS = 8'd128;

endpackage

/* sv/thrmap_mul.sv */
// 64 by 64 unsigned multiplier built from one 32 by 32 multiplier over four steps
// no dependencies
`timescale 1ns / 1ps
module thrmap_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_part;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic         r_done;
    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_p;

    // step bit 1 picks the half of a, bit 0 the half of b
    assign w_ah = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_bh = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_p  = w_ah * w_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_part <= w_p;
                    r_sh   <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + ({64'b0, r_part} << {r_sh, 5'b0});
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

/* sv/thrmap_div.sv */
// restoring divider, one quotient bit a cycle, numerator given left aligned
// no dependencies
`timescale 1ns / 1ps
module thrmap_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [127:0] i_den,
    input  logic [7:0]   i_steps,
    output logic         o_done,
    output logic [127:0] o_quot
);
    logic [127:0] r_num;
    logic [127:0] r_den;
    logic [127:0] r_rem;
    logic [127:0] r_q;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [128:0] w_sh;
    logic [129:0] w_diff;
    logic         w_ge;

    assign w_sh   = {r_rem, r_num[127]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};
    assign w_ge   = !w_diff[129];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= i_steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[126:0], 1'b0};
                r_rem <= w_ge ? w_diff[127:0] : w_sh[127:0];
                r_q   <= {r_q[126:0], w_ge};
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

/* sv/thrust_mapping_rls_estimator_top.sv */
// thrust mapping estimator: scalar rls gain estimate with a timed thrust history
// a command with a nonzero gain runs one divide, a mapping reset with a nonzero hover one divide, a
// measurement drops stale entries and then runs one 128-step divide and five four-step products;
// mode 3 goes straight to the finish state; one item at a time; the next beat is taken once the
// result sits in the output register; reset (synchronous, active low) loads register defaults,
// gain and covariance, empties the history; history entries are never cleared, only the fill count
`timescale 1ns / 1ps
module thrust_mapping_rls_estimator_top #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  thrmap_pkg::t_in_item          i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output thrmap_pkg::t_out_item         o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thrmap_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import thrmap_pkg::*;
    `include "thrust_mapping_rls_estimator_top_assert.svh"

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GO      = 4'd1;
    localparam logic [3:0] S_DIV_CMD = 4'd2;
    localparam logic [3:0] S_CMD_WR  = 4'd3;
    localparam logic [3:0] S_DIV_RST = 4'd4;
    localparam logic [3:0] S_M_RD    = 4'd5;
    localparam logic [3:0] S_M_CHK   = 4'd6;
    localparam logic [3:0] S_M_T2    = 4'd7;
    localparam logic [3:0] S_M_X     = 4'd8;
    localparam logic [3:0] S_M_DIV   = 4'd9;
    localparam logic [3:0] S_M_TG    = 4'd10;
    localparam logic [3:0] S_M_E     = 4'd11;
    localparam logic [3:0] S_M_M     = 4'd12;
    localparam logic [3:0] S_M_PH    = 4'd13;
    localparam logic [3:0] S_FIN     = 4'd14;

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) return 32'sh7fffffff;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] f_abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // configuration registers
    logic [21:0] r_gravity;
    logic [15:0] r_hover;
    logic [16:0] r_forget;
    logic [19:0] r_min_age;
    logic [19:0] r_max_age;

    // estimator state
    logic [3:0]         r_state;
    t_in_item           r_item;
    logic signed [31:0] r_gain;
    logic [63:0]        r_cov;
    logic [IW-1:0]      r_head;
    logic [FW-1:0]      r_fill;
    logic signed [31:0] r_thrust;
    logic               r_upd;
    logic signed [31:0] r_t;
    logic [31:0]        r_abs_t;
    logic signed [31:0] r_e;
    logic [63:0]        r_pn;
    logic               r_out_valid;
    t_out_item          r_out;

    // history: timestamp in the upper word, throttle in the lower
    logic [63:0] r_hist_mem [HISTORY_DEPTH];
    logic [63:0] r_rd_data;

    // shared units
    logic         w_mul_start;
    logic [63:0]  w_mul_a;
    logic [63:0]  w_mul_b;
    logic         w_mul_done;
    logic [127:0] w_mul_prod;
    logic         w_div_start;
    logic [127:0] w_div_num;
    logic [127:0] w_div_den;
    logic [7:0]   w_div_steps;
    logic         w_div_done;
    logic [127:0] w_div_q;

    thrmap_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    thrmap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // apb port, writes complete in the access phase with no wait states
    logic w_cfg_wr;
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RST;
            r_hover   <= HOVER_RST;
            r_forget  <= FORGET_RST;
            r_min_age <= MIN_AGE_RST;
            r_max_age <= MAX_AGE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_GRAVITY: r_gravity <= pwdata[21:0];
                REG_HOVER:   r_hover   <= pwdata[15:0];
                REG_FORGET:  r_forget  <= pwdata[16:0];
                REG_MIN_AGE: r_min_age <= pwdata[19:0];
                REG_MAX_AGE: r_max_age <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_GRAVITY: prdata = {10'b0, r_gravity};
            REG_HOVER:   prdata = {16'b0, r_hover};
            REG_FORGET:  prdata = {15'b0, r_forget};
            REG_MIN_AGE: prdata = {12'b0, r_min_age};
            REG_MAX_AGE: prdata = {12'b0, r_max_age};
            default:     prdata = '0;
        endcase
    end

    // history read port follows the head, write slot is the tail
    logic          w_full;
    logic [FW:0]   w_tail_sum;
    logic [FW:0]   w_tail_mod;
    logic [IW-1:0] w_wr_idx;
    logic          w_wr_en;
    logic [IW-1:0] w_head_inc;

    assign w_full     = (r_fill == FW'(HISTORY_DEPTH));
    assign w_tail_sum = (FW+1)'(r_head) + (FW+1)'(r_fill);
    assign w_tail_mod = (w_tail_sum >= (FW+1)'(HISTORY_DEPTH)) ?
                        w_tail_sum - (FW+1)'(HISTORY_DEPTH) : w_tail_sum;
    assign w_wr_idx   = w_full ? r_head : w_tail_mod[IW-1:0];
    assign w_wr_en    = (r_state == S_CMD_WR);
    assign w_head_inc = (r_head == IW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_hist_mem[w_wr_idx] <= {r_item.timestamp_us, r_thrust};
        end
        r_rd_data <= r_hist_mem[r_head];
    end

    // datapath around the shared units
    logic [31:0]        w_age;
    logic               w_drop;
    logic               w_young;
    logic [31:0]        w_abs_g;
    logic [16:0]        w_rho;
    logic [127:0]       w_den_meas;
    logic [63:0]        w_pn;
    logic signed [31:0] w_cmd_thrust;
    logic signed [31:0] w_cmd_zero_gain;
    logic signed [31:0] w_rst_gain;
    logic signed [65:0] w_cmd_mag;
    logic signed [65:0] w_tg_mag;
    logic signed [65:0] w_tg;
    logic signed [65:0] w_e66;
    logic signed [65:0] w_ph66;
    logic signed [65:0] w_g66;
    logic signed [31:0] w_gain_upd;

    assign w_age   = r_item.timestamp_us - r_rd_data[63:32];
    assign w_drop  = (w_age > {12'b0, r_max_age});
    assign w_young = (w_age < {12'b0, r_min_age});
    assign w_abs_g = f_abs32(r_gain);
    // a zero factor is out of range and counts as the smallest step
    assign w_rho   = (r_forget == '0) ? 17'd1 : r_forget;
    // denominator rho + t^2 p, rho aligned to q64.64
    assign w_den_meas = w_mul_prod + {63'b0, w_rho, 48'b0};
    assign w_pn       = (|w_div_q[127:64]) ? '1 : w_div_q[63:0];

    assign w_cmd_mag    = $signed({18'b0, w_div_q[47:0]});
    assign w_cmd_thrust = f_sat32((r_item.desired_accel[31] ^ r_gain[31]) ?
                                  -w_cmd_mag : w_cmd_mag);
    assign w_cmd_zero_gain = (r_item.desired_accel == '0) ? 32'sd0 :
                             (r_item.desired_accel[31] ? 32'sh80000000 : 32'sh7fffffff);
    assign w_rst_gain   = f_sat32($signed({28'b0, w_div_q[37:0]}));

    // error against the predicted accel, t*g truncated toward zero
    assign w_tg_mag = $signed({18'b0, w_mul_prod[63:16]});
    assign w_tg     = (r_t[31] ^ r_gain[31]) ? -w_tg_mag : w_tg_mag;
    assign w_e66    = {{34{r_item.measured_accel[31]}}, r_item.measured_accel} - w_tg;

    assign w_ph66     = $signed({2'b0, w_mul_prod[127:64]});
    assign w_g66      = {{34{r_gain[31]}}, r_gain};
    assign w_gain_upd = f_sat32((r_t[31] != r_e[31]) ? w_g66 - w_ph66 : w_g66 + w_ph66);

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_num   = {r_cov, 64'b0};
        w_div_den   = w_den_meas;
        w_div_steps = DIV_STEPS_MEAS;
        unique case (r_state)
            S_GO: begin
                case (r_item.mode)
                    MODE_CMD: begin
                        w_div_start = (r_gain != '0);
                        w_div_num   = {f_abs32(r_item.desired_accel), 96'b0};
                        w_div_den   = {96'b0, w_abs_g};
                        w_div_steps = DIV_STEPS_CMD;
                    end
                    MODE_RST: begin
                        w_div_start = (r_hover != '0);
                        w_div_num   = {r_gravity, 106'b0};
                        w_div_den   = {112'b0, r_hover};
                        w_div_steps = DIV_STEPS_RST;
                    end
                    default: ;
                endcase
            end
            S_M_CHK: begin
                w_mul_start = !w_drop && !w_young;
                w_mul_a     = {32'b0, f_abs32(r_rd_data[31:0])};
                w_mul_b     = {32'b0, f_abs32(r_rd_data[31:0])};
            end
            S_M_T2: begin
                w_mul_start = w_mul_done;
                w_mul_a     = w_mul_prod[63:0];
                w_mul_b     = r_cov;
            end
            S_M_X: begin
                w_div_start = w_mul_done;
            end
            S_M_DIV: begin
                w_mul_start = w_div_done;
                w_mul_a     = {32'b0, r_abs_t};
                w_mul_b     = {32'b0, w_abs_g};
            end
            S_M_E: begin
                w_mul_start = 1'b1;
                w_mul_a     = {32'b0, r_abs_t};
                w_mul_b     = {32'b0, f_abs32(r_e)};
            end
            S_M_M: begin
                w_mul_start = w_mul_done;
                w_mul_a     = r_pn;
                w_mul_b     = w_mul_prod[63:0];
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_RST;
            r_cov       <= COV_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish state reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item   <= i_in_data;
                        r_thrust <= '0;
                        r_upd    <= 1'b0;
                        r_state  <= S_GO;
                    end
                end
                S_GO: begin
                    case (r_item.mode)
                        MODE_CMD: begin
                            if (r_gain == '0) begin
                                r_thrust <= w_cmd_zero_gain;
                                r_state  <= S_CMD_WR;
                            end else begin
                                r_state <= S_DIV_CMD;
                            end
                        end
                        MODE_MEAS: r_state <= S_M_RD;
                        MODE_RST: begin
                            r_cov <= COV_RST;
                            if (r_hover == '0) begin
                                r_gain  <= 32'sh7fffffff;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_DIV_RST;
                            end
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_DIV_CMD: begin
                    if (w_div_done) begin
                        r_thrust <= w_cmd_thrust;
                        r_state  <= S_CMD_WR;
                    end
                end
                S_CMD_WR: begin
                    // full history: overwrite the oldest slot and advance the head
                    if (w_full) begin
                        r_head <= w_head_inc;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_DIV_RST: begin
                    if (w_div_done) begin
                        r_gain  <= w_rst_gain;
                        r_state <= S_FIN;
                    end
                end
                S_M_RD: begin
                    r_state <= (r_fill == '0) ? S_FIN : S_M_CHK;
                end
                S_M_CHK: begin
                    if (w_drop) begin
                        r_head  <= w_head_inc;
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_M_RD;
                    end else if (w_young) begin
                        r_state <= S_FIN;
                    end else begin
                        r_t     <= r_rd_data[31:0];
                        r_abs_t <= f_abs32(r_rd_data[31:0]);
                        r_head  <= w_head_inc;
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_M_T2;
                    end
                end
                S_M_T2: if (w_mul_done) r_state <= S_M_X;
                S_M_X:  if (w_mul_done) r_state <= S_M_DIV;
                S_M_DIV: begin
                    if (w_div_done) begin
                        r_pn    <= w_pn;
                        r_state <= S_M_TG;
                    end
                end
                S_M_TG: begin
                    if (w_mul_done) begin
                        r_e     <= f_sat32(w_e66);
                        r_state <= S_M_E;
                    end
                end
                S_M_E: r_state <= S_M_M;
                S_M_M: if (w_mul_done) r_state <= S_M_PH;
                S_M_PH: begin
                    if (w_mul_done) begin
                        r_gain  <= w_gain_upd;
                        r_cov   <= r_pn;
                        r_upd   <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid          <= 1'b1;
                        r_out.thrust_command <= r_thrust;
                        r_out.updated        <= r_upd;
                        r_out.gain_estimate  <= r_gain;
                        r_out.history_count  <= 8'(r_fill);
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TMRE_NEVER(a_fill_bound, r_fill > FW'(HISTORY_DEPTH))
    `TMRE_NEVER(a_head_bound, r_head > IW'(HISTORY_DEPTH - 1))
    `TMRE_ASSERT(a_one_item, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `TMRE_ASSERT(a_upd_fin, $rose(r_upd) |-> (r_state == S_FIN))
endmodule

/* tb/sv/thrust_mapping_rls_estimator_top_tb.sv */
// self-checking testbench for the thrust mapping rls estimator
// depends on thrmap_pkg and thrust_mapping_rls_estimator_top
`timescale 1ns / 1ps
module thrust_mapping_rls_estimator_top_tb;
    import thrmap_pkg::*;

    localparam int HIST_DEPTH  = 128;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 500;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    thrust_mapping_rls_estimator_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // estimator model: registers, gain, covariance, timed thrust fifo
    // ---------------------------------------------------------------
    logic [21:0] cfg_gravity;
    logic [15:0] cfg_hover;
    logic [16:0] cfg_forget;
    logic [19:0] cfg_min_age;
    logic [19:0] cfg_max_age;
    longint      gain_est;
    logic [63:0] cov_est;
    logic [31:0] hist_time [HIST_DEPTH];
    longint      hist_thr  [HIST_DEPTH];
    int          hist_head;
    int          hist_fill;

    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic void reload_mapping();
        if (cfg_hover == 0)
            gain_est = S32_MAX;
        else
            gain_est = sat32((longint'(cfg_gravity) <<< 16) / longint'(cfg_hover));
        cov_est = COV_RST;
    endfunction

    function automatic void reset_model();
        cfg_gravity = GRAVITY_RST;
        cfg_hover   = HOVER_RST;
        cfg_forget  = FORGET_RST;
        cfg_min_age = MIN_AGE_RST;
        cfg_max_age = MAX_AGE_RST;
        hist_head   = 0;
        hist_fill   = 0;
        reload_mapping();
    endfunction

    // drop stale entries, then pop the oldest usable one and run an rls step
    function automatic logic rls_measure(logic [31:0] now, longint accel);
        logic [31:0]  age;
        longint       thr;
        longint       err;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] corr;
        logic [63:0]  cov_next;
        logic [63:0]  rho;
        logic [63:0]  m;
        while (hist_fill > 0) begin
            age = now - hist_time[hist_head];
            if (age > 32'(cfg_max_age)) begin
                hist_head = (hist_head + 1) % HIST_DEPTH;
                hist_fill--;
                continue;
            end
            if (age < 32'(cfg_min_age)) return 1'b0;
            thr = hist_thr[hist_head];
            hist_head = (hist_head + 1) % HIST_DEPTH;
            hist_fill--;
            rho = (cfg_forget == 0) ? 64'd1 : 64'(cfg_forget);
            den = 128'(mag64(thr) * mag64(thr)) * 128'(cov_est) + (128'(rho) << 48);
            quo = {cov_est, 64'd0} / den;
            cov_next = (quo[127:64] != 0) ? '1 : quo[63:0];
            err = sat32(accel - (thr * gain_est) / 64'sd65536);
            m = mag64(thr) * mag64(err);
            corr = 128'(cov_next) * 128'(m);
            if ((thr < 0) != (err < 0))
                gain_est = sat32(gain_est - longint'(corr[127:64]));
            else
                gain_est = sat32(gain_est + longint'(corr[127:64]));
            cov_est = cov_next;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item predict_beat(t_in_item it);
        t_out_item r;
        longint d;
        longint thr;
        int slot;
        thr = 0;
        r = '0;
        case (it.mode)
            MODE_CMD: begin
                d = longint'(it.desired_accel);
                if (gain_est == 0)
                    thr = (d > 0) ? S32_MAX : ((d < 0) ? S32_MIN : 0);
                else
                    thr = sat32((d * 64'sd65536) / gain_est);
                if (hist_fill >= HIST_DEPTH) begin
                    hist_head = (hist_head + 1) % HIST_DEPTH;
                    hist_fill = HIST_DEPTH - 1;
                end
                slot = (hist_head + hist_fill) % HIST_DEPTH;
                hist_time[slot] = it.timestamp_us;
                hist_thr[slot]  = thr;
                hist_fill++;
            end
            MODE_MEAS: r.updated = rls_measure(it.timestamp_us, longint'(it.measured_accel));
            MODE_RST:  reload_mapping();
            default: ;
        endcase
        r.thrust_command = 32'(thr);
        r.gain_estimate  = 32'(gain_est);
        r.history_count  = 8'(hist_fill);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // shared state between stimulus, driver and monitor
    // ---------------------------------------------------------------
    t_in_item  pending_beats[$];
    t_out_item expected_results[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_req = 0;      // long receiver hold-off, armed by the stimulus
    int        hold_cnt = 0;
    int        errors = 0;
    int        quiet_cycles = 0;
    logic [31:0] now_us;

    // driver: one nonblocking update of valid/data per edge
    always @(posedge i_clk) begin
        logic offer;
        logic next_valid;
        t_in_item next_data;
        offer = 1'b0;
        next_valid = i_in_valid;
        next_data = i_in_data;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_beat(i_in_data));
                offer = 1'b1;
            end else if (!i_in_valid) begin
                offer = 1'b1;
            end
            if (offer) begin
                if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_valid = 1'b1;
                    next_data = pending_beats.pop_front();
                end else begin
                    next_valid = 1'b0;
                end
            end
        end
        i_in_valid <= next_valid;
        i_in_data <= next_data;
    end

    // monitor: compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %p", $realtime, o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.thrust_command !== want.thrust_command) begin
                    errors++;
                    $display("%0t: thrust_command expected %0d actual %0d", $realtime,
                             want.thrust_command, o_out_data.thrust_command);
                end
                if (o_out_data.updated !== want.updated) begin
                    errors++;
                    $display("%0t: updated expected %0d actual %0d", $realtime,
                             want.updated, o_out_data.updated);
                end
                if (o_out_data.gain_estimate !== want.gain_estimate) begin
                    errors++;
                    $display("%0t: gain_estimate expected %0d actual %0d", $realtime,
                             want.gain_estimate, o_out_data.gain_estimate);
                end
                if (o_out_data.history_count !== want.history_count) begin
                    errors++;
                    $display("%0t: history_count expected %0d actual %0d", $realtime,
                             want.history_count, o_out_data.history_count);
                end
            end
        end
        // hold-off counted here so the block backs up against a stalled output
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("thrust_mapping_rls_estimator_top_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_beat(logic [1:0] mode, logic [31:0] ts, logic [31:0] des,
                              logic [31:0] meas);
        t_in_item it;
        it.mode = mode;
        it.timestamp_us = ts;
        it.desired_accel = des;
        it.measured_accel = meas;
        pending_beats.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || i_in_valid || expected_results.size() != 0 ||
               hold_cnt != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle; model follows at the access edge
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GRAVITY: cfg_gravity = val[21:0];
            REG_HOVER:   cfg_hover   = val[15:0];
            REG_FORGET:  cfg_forget  = val[16:0];
            REG_MIN_AGE: cfg_min_age = val[19:0];
            REG_MAX_AGE: cfg_max_age = val[19:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [31:0] grav, logic [31:0] hov, logic [31:0] rho,
                               logic [31:0] amin, logic [31:0] amax);
        reg_write(REG_GRAVITY, grav);
        reg_write(REG_HOVER, hov);
        reg_write(REG_FORGET, rho);
        reg_write(REG_MIN_AGE, amin);
        reg_write(REG_MAX_AGE, amax);
        // new gravity and hover values only apply after a mapping reset
        queue_beat(MODE_RST, now_us, $urandom, $urandom);
    endtask

    function automatic logic [31:0] rand_accel();
        if ($urandom_range(0, 1))
            return $urandom;
        return 32'($urandom_range(0, 40 << 16)) - 32'(20 << 16);
    endfunction

    // mostly commands and measurements, plus mapping resets and mode 3 beats; some timestamps are random
    task automatic queue_random(int n);
        int pick;
        logic [31:0] ts;
        repeat (n) begin
            now_us += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 100)
                                                  : $urandom_range(0, 8000);
            ts = ($urandom_range(0, 19) == 0) ? $urandom : now_us;
            pick = $urandom_range(0, 99);
            if (pick < 48)
                queue_beat(MODE_CMD, ts, rand_accel(), $urandom);
            else if (pick < 90)
                queue_beat(MODE_MEAS, ts, $urandom, rand_accel());
            else if (pick < 95)
                queue_beat(MODE_RST, ts, $urandom, $urandom);
            else
                queue_beat(2'd3, ts, $urandom, $urandom);
        end
    endtask

    // dense command run that overflows the history
    task automatic queue_burst(int n);
        repeat (n) begin
            now_us += 10;
            queue_beat(MODE_CMD, now_us, rand_accel(), $urandom);
        end
    endtask

    initial begin
        reset_model();
        now_us = 32'hFFFF_0000;   // time wraps early in the run
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with reset defaults
        send_idle_pct = 37;
        recv_idle_pct = 86;
        queue_beat(MODE_MEAS, now_us, 0, 32'h7FFF_FFFF);        // empty history
        queue_beat(MODE_CMD, now_us, 0, 0);
        queue_beat(MODE_CMD, now_us + 1000, 32'h7FFF_FFFF, 0);
        queue_beat(MODE_CMD, now_us + 2000, 32'h8000_0000, 0);
        queue_beat(MODE_CMD, now_us + 3000, 32'd1, 0);
        queue_beat(MODE_CMD, now_us + 4000, 32'hFFFF_FFFF, 0);
        queue_beat(MODE_MEAS, now_us + 10000, 0, 0);            // too young
        now_us += 40000;
        queue_beat(MODE_MEAS, now_us, 0, 32'h7FFF_FFFF);
        queue_beat(MODE_MEAS, now_us + 500, 0, 32'h8000_0000);
        queue_beat(MODE_MEAS, now_us + 1000, 0, 32'd0);
        queue_beat(MODE_MEAS, now_us + 1500, 0, 32'hFFFF_0000);
        queue_beat(MODE_MEAS, now_us + 100000, 0, 0);           // everything stale
        queue_beat(MODE_CMD, now_us + 200000, 32'h0009_CE80, 0); // entry in the future
        queue_beat(MODE_MEAS, now_us, 0, 32'h0001_0000);        // looks very old
        queue_beat(MODE_RST, now_us, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(2'd3, 0, 0, 0);
        queue_random(120);
        wait_idle();

        // extreme gravity, tiny forgetting factor, wide age window
        load_config(2097152, 65535, 1, 0, 1000000);
        queue_burst(140);
        queue_random(60);
        wait_idle();

        send_idle_pct = 86;
        recv_idle_pct = 37;
        load_config(642908, 1, 65536, 35000, 45000);
        queue_random(120);
        wait_idle();

        // hover zero and forgetting factor zero, both out of range
        load_config(1234567, 0, 0, 1000, 20000);
        queue_random(80);
        wait_idle();

        // zero gain and an age window that can never match
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(0, 12345, 40000, 1000000, 0);
        queue_random(50);
        wait_idle();

        load_config(642908, 19661, 65405, 35000, 45000);
        hold_req = 3000;
        queue_random(60);
        wait_idle();

        if (errors == 0) begin
            $display("thrust_mapping_rls_estimator_top_tb: clean");
        end else begin
            $display("thrust_mapping_rls_estimator_top_tb: errors");
        end
        $finish;
    end
endmodule
